[sv/mpq_pkg.sv]
// Package with the request and response types, command codes and controller states.
package mpq_pkg;

   localparam int CMD_W    = 4;
   localparam int SLOT_W   = 5;
   localparam int QUEUE_W  = 4;
   localparam int SENDER_W = 6;

   localparam int DEF_SLOT_COUNT  = 32;
   localparam int DEF_QUEUE_COUNT = 16;

   localparam logic [CMD_W-1:0] CMD_INIT   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_FREE   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 4'd3;
   localparam logic [CMD_W-1:0] CMD_PUSH   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_POP    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_HEAD   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_EMPTY  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd8;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [SLOT_W-1:0]   slot_index;
      logic [QUEUE_W-1:0]  queue_id;
      logic [SENDER_W-1:0] sender_id;
   } request_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   result_slot;
      logic                ok;
      logic                is_empty;
      logic [SENDER_W-1:0] result_sender;
   } response_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_QH_RD,
      ST_QH_CHK,
      ST_HEAD_SND,
      ST_WALK,
      ST_CLR_WALK,
      ST_CLR_END,
      ST_DET_RD,
      ST_DET_CAP,
      ST_DET_A,
      ST_DET_B,
      ST_DET_C,
      ST_LNK_RD,
      ST_LNK_A,
      ST_LNK_B,
      ST_EMP_RD,
      ST_EMP_CHK
   } state_type;

endpackage

[sv/message_pool_queue_manager.sv]
// Message pool queue manager: linked slot lists in a slot memory and a list head/tail memory.
// A pop by sender walks the queue at one slot per cycle through the slot memory read port,
// and a clear walks the whole queue the same way.
// Reset and the init command sweep both memories, one entry per cycle, with busy high;
// reset gives no response.
// The response is shown for one cycle and cannot be stalled; busy drops in that cycle.
module message_pool_queue_manager #(
   parameter int SLOT_COUNT  = mpq_pkg::DEF_SLOT_COUNT,
   parameter int QUEUE_COUNT = mpq_pkg::DEF_QUEUE_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mpq_pkg::request_type  req_data,
   output logic                  rsp_valid,
   output mpq_pkg::response_type rsp_data
);
   import mpq_pkg::*;

   localparam int LIST_COUNT = QUEUE_COUNT + 1;
   localparam int MAX_N      = (SLOT_COUNT > LIST_COUNT) ? SLOT_COUNT : LIST_COUNT;
   localparam int SW         = $clog2(SLOT_COUNT + 1);
   localparam int SAW        = $clog2(SLOT_COUNT);
   localparam int OW         = $clog2(QUEUE_COUNT + 2);
   localparam int LAW        = $clog2(QUEUE_COUNT + 1);
   localparam int CW         = $clog2(MAX_N + 1);

   localparam logic [SW-1:0]  NONE_LINK = SW'(SLOT_COUNT);
   localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOT_COUNT - 1);
   localparam logic [OW-1:0]  DETACHED  = OW'(QUEUE_COUNT + 1);
   localparam logic [OW-1:0]  OWN_LISTS = OW'(LIST_COUNT);
   localparam logic [LAW-1:0] FREE_IDX  = LAW'(QUEUE_COUNT);
   localparam logic [CW-1:0]  CNT_LAST  = CW'(MAX_N - 1);
   localparam logic [CW-1:0]  CNT_SLOTS = CW'(SLOT_COUNT);
   localparam logic [CW-1:0]  CNT_LISTS = CW'(LIST_COUNT);

   logic [SW-1:0]       next_mem   [SLOT_COUNT];
   logic [SW-1:0]       prev_mem   [SLOT_COUNT];
   logic [OW-1:0]       owner_mem  [SLOT_COUNT];
   logic [SENDER_W-1:0] sender_mem [SLOT_COUNT];
   logic [SW-1:0]       head_mem   [LIST_COUNT];
   logic [SW-1:0]       tail_mem   [LIST_COUNT];

   logic [SW-1:0]       sn_rd;
   logic [SW-1:0]       sp_rd;
   logic [OW-1:0]       so_rd;
   logic [SENDER_W-1:0] ss_rd;
   logic [SW-1:0]       lh_rd;
   logic [SW-1:0]       lt_rd;

   logic [SAW-1:0]      s_raddr;
   logic [SAW-1:0]      s_waddr;
   logic                s_we_next;
   logic                s_we_prev;
   logic                s_we_owner;
   logic                s_we_sender;
   logic [SW-1:0]       s_wnext;
   logic [SW-1:0]       s_wprev;
   logic [OW-1:0]       s_wowner;
   logic [SENDER_W-1:0] s_wsender;
   logic [LAW-1:0]      l_raddr;
   logic [LAW-1:0]      l_waddr;
   logic                l_we_head;
   logic                l_we_tail;
   logic [SW-1:0]       l_whead;
   logic [SW-1:0]       l_wtail;

   state_type           state_ff, state_in;
   logic                boot_ff, boot_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic                q_ok_ff, q_ok_in;
   logic [LAW-1:0]      q_addr_ff, q_addr_in;
   logic [LAW-1:0]      lst_ff, lst_in;
   logic [SENDER_W-1:0] snd_ff, snd_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       nb_ff, nb_in;
   logic [OW-1:0]       own_ff, own_in;
   logic [SW-1:0]       prv_ff, prv_in;
   logic [SW-1:0]       nxt_ff, nxt_in;
   logic [SW-1:0]       rslot_ff, rslot_in;
   logic [SENDER_W-1:0] rsnd_ff, rsnd_in;
   logic                ok_ff, ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   response_type        rsp_ff, rsp_in;

   logic                accept;
   logic                slot_ok;
   logic                q_ok;
   logic                match;
   logic                attached;
   logic                back;
   logic [SW-1:0]       lnk_nb;

   assign accept   = start && (state_ff == ST_IDLE);
   assign slot_ok  = 32'(req_data.slot_index) < 32'(SLOT_COUNT);
   assign q_ok     = 32'(req_data.queue_id) < 32'(QUEUE_COUNT);
   assign match    = (snd_ff == '0) || (ss_rd == snd_ff);
   assign attached = own_ff < OWN_LISTS;
   assign back     = cmd_ff == CMD_INSERT;
   assign lnk_nb   = back ? lt_rd : lh_rd;

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (s_we_next) begin
         next_mem[s_waddr] <= s_wnext;
      end
      if (s_we_prev) begin
         prev_mem[s_waddr] <= s_wprev;
      end
      if (s_we_owner) begin
         owner_mem[s_waddr] <= s_wowner;
      end
      if (s_we_sender) begin
         sender_mem[s_waddr] <= s_wsender;
      end
      sn_rd <= next_mem[s_raddr];
      sp_rd <= prev_mem[s_raddr];
      so_rd <= owner_mem[s_raddr];
      ss_rd <= sender_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (l_we_head) begin
         head_mem[l_waddr] <= l_whead;
      end
      if (l_we_tail) begin
         tail_mem[l_waddr] <= l_wtail;
      end
      lh_rd <= head_mem[l_raddr];
      lt_rd <= tail_mem[l_raddr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.cmd)
                  CMD_INIT:   state_in = ST_SWEEP;
                  CMD_ALLOC:  state_in = ST_FREE_RD;
                  CMD_FREE:   state_in = slot_ok ? ST_DET_RD : ST_EMP_RD;
                  CMD_INSERT: state_in = (slot_ok && q_ok) ? ST_DET_RD : ST_EMP_RD;
                  CMD_PUSH:   state_in = (slot_ok && q_ok) ? ST_DET_RD : ST_EMP_RD;
                  CMD_POP:    state_in = q_ok ? ST_QH_RD : ST_EMP_RD;
                  CMD_HEAD:   state_in = q_ok ? ST_QH_RD : ST_EMP_RD;
                  CMD_CLEAR:  state_in = q_ok ? ST_QH_RD : ST_EMP_RD;
                  default:    state_in = ST_EMP_RD;
               endcase
            end
         end
         ST_SWEEP: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = boot_ff ? ST_IDLE : ST_EMP_RD;
            end
         end
         ST_FREE_RD:  state_in = ST_FREE_CHK;
         ST_FREE_CHK: state_in = (lh_rd < NONE_LINK) ? ST_DET_RD : ST_EMP_RD;
         ST_QH_RD:    state_in = ST_QH_CHK;
         ST_QH_CHK: begin
            if (lh_rd < NONE_LINK) begin
               case (cmd_ff)
                  CMD_POP:   state_in = ST_WALK;
                  CMD_CLEAR: state_in = ST_CLR_WALK;
                  default:   state_in = ST_HEAD_SND;
               endcase
            end else begin
               state_in = (cmd_ff == CMD_CLEAR) ? ST_CLR_END : ST_EMP_RD;
            end
         end
         ST_HEAD_SND: state_in = ST_EMP_RD;
         ST_WALK: begin
            if (match) begin
               state_in = ST_DET_A;
            end else if (!(sn_rd < NONE_LINK)) begin
               state_in = ST_EMP_RD;
            end
         end
         ST_CLR_WALK: begin
            if (!(sn_rd < NONE_LINK)) begin
               state_in = ST_CLR_END;
            end
         end
         ST_CLR_END: state_in = ST_EMP_RD;
         ST_DET_RD:  state_in = ST_DET_CAP;
         ST_DET_CAP: state_in = ST_DET_A;
         ST_DET_A:   state_in = ST_DET_B;
         ST_DET_B: begin
            if (cmd_ff == CMD_ALLOC || cmd_ff == CMD_POP) begin
               state_in = ST_DET_C;
            end else begin
               state_in = ST_LNK_RD;
            end
         end
         ST_DET_C:   state_in = ST_EMP_RD;
         ST_LNK_RD:  state_in = ST_LNK_A;
         ST_LNK_A:   state_in = ST_LNK_B;
         ST_LNK_B:   state_in = ST_EMP_RD;
         ST_EMP_RD:  state_in = ST_EMP_CHK;
         ST_EMP_CHK: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      s_raddr     = cur_ff[SAW-1:0];
      s_waddr     = cur_ff[SAW-1:0];
      s_we_next   = 1'b0;
      s_we_prev   = 1'b0;
      s_we_owner  = 1'b0;
      s_we_sender = 1'b0;
      s_wnext     = NONE_LINK;
      s_wprev     = NONE_LINK;
      s_wowner    = DETACHED;
      s_wsender   = '0;
      l_raddr     = q_addr_ff;
      l_waddr     = q_addr_ff;
      l_we_head   = 1'b0;
      l_we_tail   = 1'b0;
      l_whead     = NONE_LINK;
      l_wtail     = NONE_LINK;
      case (state_ff)
         ST_SWEEP: begin
            s_waddr     = cnt_ff[SAW-1:0];
            s_we_next   = cnt_ff < CNT_SLOTS;
            s_we_prev   = cnt_ff < CNT_SLOTS;
            s_we_owner  = cnt_ff < CNT_SLOTS;
            s_we_sender = cnt_ff < CNT_SLOTS;
            s_wnext     = (cnt_ff == '0) ? NONE_LINK : SW'(cnt_ff - 1'b1);
            s_wprev     = (SW'(cnt_ff) == LAST_SLOT) ? NONE_LINK : SW'(cnt_ff + 1'b1);
            s_wowner    = OW'(FREE_IDX);
            l_waddr     = cnt_ff[LAW-1:0];
            l_we_head   = cnt_ff < CNT_LISTS;
            l_we_tail   = cnt_ff < CNT_LISTS;
            l_whead     = (cnt_ff[LAW-1:0] == FREE_IDX) ? LAST_SLOT : NONE_LINK;
            l_wtail     = (cnt_ff[LAW-1:0] == FREE_IDX) ? '0 : NONE_LINK;
         end
         ST_FREE_RD: begin
            l_raddr = FREE_IDX;
         end
         ST_QH_CHK: begin
            s_raddr = lh_rd[SAW-1:0];
         end
         ST_WALK: begin
            if (!match) begin
               s_raddr = sn_rd[SAW-1:0];
            end
         end
         ST_CLR_WALK: begin
            s_raddr    = sn_rd[SAW-1:0];
            s_we_next  = 1'b1;
            s_we_prev  = 1'b1;
            s_we_owner = 1'b1;
         end
         ST_CLR_END: begin
            l_we_head = 1'b1;
            l_we_tail = 1'b1;
         end
         ST_DET_A: begin
            if (attached) begin
               if (prv_ff < NONE_LINK) begin
                  s_waddr   = prv_ff[SAW-1:0];
                  s_we_next = 1'b1;
                  s_wnext   = nxt_ff;
               end else begin
                  l_waddr   = own_ff[LAW-1:0];
                  l_we_head = 1'b1;
                  l_whead   = nxt_ff;
               end
            end
         end
         ST_DET_B: begin
            if (attached) begin
               if (nxt_ff < NONE_LINK) begin
                  s_waddr   = nxt_ff[SAW-1:0];
                  s_we_prev = 1'b1;
                  s_wprev   = prv_ff;
               end else begin
                  l_waddr   = own_ff[LAW-1:0];
                  l_we_tail = 1'b1;
                  l_wtail   = prv_ff;
               end
            end
         end
         ST_DET_C: begin
            s_we_next   = 1'b1;
            s_we_prev   = 1'b1;
            s_we_owner  = 1'b1;
            s_we_sender = cmd_ff == CMD_ALLOC;
         end
         ST_LNK_RD: begin
            l_raddr = lst_ff;
         end
         ST_LNK_A: begin
            s_we_next   = 1'b1;
            s_we_prev   = 1'b1;
            s_we_owner  = 1'b1;
            s_we_sender = cmd_ff != CMD_FREE;
            s_wnext     = back ? NONE_LINK : lnk_nb;
            s_wprev     = back ? lnk_nb : NONE_LINK;
            s_wowner    = OW'(lst_ff);
            s_wsender   = snd_ff;
            l_waddr     = lst_ff;
            l_we_head   = !back || !(lnk_nb < NONE_LINK);
            l_we_tail   = back || !(lnk_nb < NONE_LINK);
            l_whead     = cur_ff;
            l_wtail     = cur_ff;
         end
         ST_LNK_B: begin
            s_waddr   = nb_ff[SAW-1:0];
            s_we_next = back && (nb_ff < NONE_LINK);
            s_we_prev = !back && (nb_ff < NONE_LINK);
            s_wnext   = cur_ff;
            s_wprev   = cur_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      boot_in      = boot_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      q_ok_in      = q_ok_ff;
      q_addr_in    = q_addr_ff;
      lst_in       = lst_ff;
      snd_in       = snd_ff;
      cur_in       = cur_ff;
      nb_in        = nb_ff;
      own_in       = own_ff;
      prv_in       = prv_ff;
      nxt_in       = nxt_ff;
      rslot_in     = rslot_ff;
      rsnd_in      = rsnd_ff;
      ok_in        = ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               boot_in   = 1'b0;
               cnt_in    = '0;
               cmd_in    = req_data.cmd;
               q_ok_in   = q_ok;
               q_addr_in = LAW'(req_data.queue_id);
               lst_in    = (req_data.cmd == CMD_FREE) ? FREE_IDX : LAW'(req_data.queue_id);
               snd_in    = req_data.sender_id;
               cur_in    = SW'(req_data.slot_index);
               rslot_in  = '0;
               rsnd_in   = '0;
               ok_in     = 1'b0;
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
         end
         ST_FREE_CHK: begin
            if (lh_rd < NONE_LINK) begin
               cur_in   = lh_rd;
               rslot_in = lh_rd;
               ok_in    = 1'b1;
            end
         end
         ST_QH_CHK: begin
            cur_in = lh_rd;
         end
         ST_HEAD_SND: begin
            rslot_in = cur_ff;
            rsnd_in  = ss_rd;
            ok_in    = 1'b1;
         end
         ST_WALK: begin
            if (match) begin
               rslot_in = cur_ff;
               rsnd_in  = ss_rd;
               ok_in    = 1'b1;
               own_in   = so_rd;
               prv_in   = sp_rd;
               nxt_in   = sn_rd;
            end else begin
               cur_in = sn_rd;
            end
         end
         ST_CLR_WALK: begin
            cur_in = sn_rd;
         end
         ST_DET_CAP: begin
            own_in = so_rd;
            prv_in = sp_rd;
            nxt_in = sn_rd;
         end
         ST_LNK_A: begin
            nb_in = lnk_nb;
         end
         ST_EMP_CHK: begin
            rsp_valid_in         = 1'b1;
            rsp_in.result_slot   = SLOT_W'(rslot_ff);
            rsp_in.ok            = ok_ff;
            rsp_in.is_empty      = !q_ok_ff || !(lh_rd < NONE_LINK);
            rsp_in.result_sender = rsnd_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         boot_ff      <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      q_ok_ff   <= q_ok_in;
      q_addr_ff <= q_addr_in;
      lst_ff    <= lst_in;
      snd_ff    <= snd_in;
      cur_ff    <= cur_in;
      nb_ff     <= nb_in;
      own_ff    <= own_in;
      prv_ff    <= prv_in;
      nxt_ff    <= nxt_in;
      rslot_ff  <= rslot_in;
      rsnd_ff   <= rsnd_in;
      ok_ff     <= ok_in;
      rsp_ff    <= rsp_in;
   end

endmodule
